// File: rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the stick auto-center learner.
// No dependencies; every other file in rtl/ uses this package.
package sacl_pkg;

	localparam int AxisW       = 12;
	localparam int SumW        = 17;
	localparam int CountW      = 5;
	localparam int PackedW     = 24;
	localparam int SamplesDef  = 20;
	// Fixed-point shift of the reciprocal: exact for any SumW-bit sum and divisor < 2**CountW
	localparam int RecipShift  = SumW + CountW;

	localparam logic [AxisW-1:0] AXIS_MID   = 12'd2048;
	localparam logic [AxisW-1:0] WINDOW_RST = 12'd256;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_RESET  = 1'b1;

	typedef logic [AxisW-1:0]  axis_t;
	typedef logic [SumW-1:0]   sum_t;
	typedef logic [CountW-1:0] count_t;

	typedef struct packed {
		axis_t ry;
		axis_t rx;
		axis_t ly;
		axis_t lx;
	} axes_t;

	typedef struct packed {
		sum_t ry;
		sum_t rx;
		sum_t ly;
		sum_t lx;
	} sums_t;

	typedef struct packed {
		logic                op;
		logic                source;
		logic [PackedW-1:0]  left_packed;
		logic [PackedW-1:0]  right_packed;
		logic                buttons_held;
	} sample_t;

	typedef struct packed {
		axis_t left_x;
		axis_t left_y;
		axis_t right_x;
		axis_t right_y;
		axis_t center_left_x;
		axis_t center_left_y;
		axis_t center_right_x;
		axis_t center_right_y;
		logic  is_calibrated;
		logic  learned_now;
	} result_t;

	// True when the axis lies within win of the midpoint (inclusive)
	function automatic logic near_mid(input axis_t v, input axis_t win);
		axis_t offset;
		offset = (v >= AXIS_MID) ? (v - AXIS_MID) : (AXIS_MID - v);
		return offset <= win;
	endfunction

endpackage

// File: rtl/sacl_sample_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one stick sample item.
// Depends on sacl_pkg for the payload type.
interface sacl_sample_if;
	logic              valid;
	logic              ready;
	sacl_pkg::sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sacl_result_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one result item of the learner.
// Depends on sacl_pkg for the payload type.
interface sacl_result_if;
	logic              valid;
	logic              ready;
	sacl_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/stick_auto_center_learner_core.sv
`timescale 1ns / 1ps
// Stick auto-center learner: per-context rest detection, sums and center learning.
// Depends on sacl_pkg, sacl_sample_if and sacl_result_if.
//
//  Channel   Kind          Direction  Contents
//  sample    valid/ready   in         op, source, left/right packed sticks, buttons_held
//  result    valid/ready   out        axes, learned centers, is_calibrated, learned_now
//  cfg       write enable  in         center_window (12 bit)
//
// One item per cycle sustained while the result is taken; an item is captured in the input
// register and its result is then offered from the result register. The rest test,
// the compare/add/count update and the divide by SAMPLES (a reciprocal multiply)
// all sit between those two registers, so the per-context state updates as the item advances.
// Reset puts both contexts to centers 2048, uncalibrated, window 256.
// A stalled result holds the input register, which then holds off new items.
module stick_auto_center_learner_core #(
	parameter int SAMPLES = sacl_pkg::SamplesDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sacl_sample_if.sink                  sample,
	sacl_result_if.source                result,
	input  logic                         cfg_we,
	input  logic [sacl_pkg::AxisW-1:0]   cfg_wdata
);

	localparam int RecipW = sacl_pkg::RecipShift + 1;
	localparam int ProdW  = sacl_pkg::SumW + RecipW;
	localparam longint unsigned RecipVal =
		((64'd1 << sacl_pkg::RecipShift) + SAMPLES - 1) / SAMPLES;
	localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);
	localparam sacl_pkg::count_t SamplesC = sacl_pkg::CountW'(SAMPLES);
	localparam sacl_pkg::axes_t MidAxes = '{
		ry: sacl_pkg::AXIS_MID, rx: sacl_pkg::AXIS_MID,
		ly: sacl_pkg::AXIS_MID, lx: sacl_pkg::AXIS_MID
	};

	// Configuration
	sacl_pkg::axis_t window_q;

	// Per-context learning state
	logic             done_q  [2];
	sacl_pkg::count_t count_q [2];
	sacl_pkg::sums_t  sums_q  [2];
	sacl_pkg::axes_t  centers_q [2];

	// Stage 1: input register
	logic              valid_s1;
	sacl_pkg::sample_t item_s1;

	// Output register
	logic              out_valid_q;
	sacl_pkg::result_t result_q;

	logic adv1;

	// Handshake: the input register moves when the output register is empty or draining
	assign adv1         = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv1;
	assign result.valid = out_valid_q;
	assign result.data  = result_q;

	// Hold the window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= sacl_pkg::WINDOW_RST;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1 <= sample.data;
		end
	end

	// Divide a sum by SAMPLES through the reciprocal
	function automatic sacl_pkg::axis_t div_samples(input sacl_pkg::sum_t s);
		logic [ProdW-1:0] prod;
		prod = ProdW'(s) * ProdW'(Recip);
		return prod[sacl_pkg::RecipShift +: sacl_pkg::AxisW];
	endfunction

	// Stage 1 logic: rest test, running sums and count, centers and result
	logic              ctx;
	sacl_pkg::axes_t   axes;
	logic              resting;
	sacl_pkg::count_t  count_inc;
	sacl_pkg::sums_t   sums_inc;
	logic              learn;
	logic              done_after;
	sacl_pkg::axes_t   quot;
	sacl_pkg::axes_t   center_out;
	sacl_pkg::result_t result_d;

	always_comb begin
		ctx     = item_s1.source;
		axes.lx = item_s1.left_packed[sacl_pkg::AxisW-1:0];
		axes.ly = item_s1.left_packed[sacl_pkg::PackedW-1:sacl_pkg::AxisW];
		axes.rx = item_s1.right_packed[sacl_pkg::AxisW-1:0];
		axes.ry = item_s1.right_packed[sacl_pkg::PackedW-1:sacl_pkg::AxisW];
		resting = !item_s1.buttons_held
			&& sacl_pkg::near_mid(axes.lx, window_q)
			&& sacl_pkg::near_mid(axes.ly, window_q)
			&& sacl_pkg::near_mid(axes.rx, window_q)
			&& sacl_pkg::near_mid(axes.ry, window_q);
		count_inc   = count_q[ctx] + sacl_pkg::CountW'(1);
		sums_inc.lx = sums_q[ctx].lx + sacl_pkg::SumW'(axes.lx);
		sums_inc.ly = sums_q[ctx].ly + sacl_pkg::SumW'(axes.ly);
		sums_inc.rx = sums_q[ctx].rx + sacl_pkg::SumW'(axes.rx);
		sums_inc.ry = sums_q[ctx].ry + sacl_pkg::SumW'(axes.ry);
		learn = (item_s1.op == sacl_pkg::OP_SAMPLE) && !done_q[ctx] && resting
			&& (count_inc >= SamplesC);
		done_after = (item_s1.op == sacl_pkg::OP_RESET) ? 1'b0 : (done_q[ctx] || learn);
		quot.lx = div_samples(sums_inc.lx);
		quot.ly = div_samples(sums_inc.ly);
		quot.rx = div_samples(sums_inc.rx);
		quot.ry = div_samples(sums_inc.ry);
		if (learn) begin
			center_out = quot;
		end else if (item_s1.op == sacl_pkg::OP_RESET) begin
			center_out = MidAxes;
		end else begin
			center_out = centers_q[ctx];
		end
		result_d.left_x         = done_after ? axes.lx : sacl_pkg::AXIS_MID;
		result_d.left_y         = done_after ? axes.ly : sacl_pkg::AXIS_MID;
		result_d.right_x        = done_after ? axes.rx : sacl_pkg::AXIS_MID;
		result_d.right_y        = done_after ? axes.ry : sacl_pkg::AXIS_MID;
		result_d.center_left_x  = center_out.lx;
		result_d.center_left_y  = center_out.ly;
		result_d.center_right_x = center_out.rx;
		result_d.center_right_y = center_out.ry;
		result_d.is_calibrated  = done_after;
		result_d.learned_now    = learn;
	end

	// Update per-context sums, count and done flag as the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				done_q[c]  <= 1'b0;
				count_q[c] <= '0;
				sums_q[c]  <= '0;
			end
		end else if (adv1) begin
			if (item_s1.op == sacl_pkg::OP_RESET) begin
				for (int c = 0; c < 2; c++) begin
					done_q[c]  <= 1'b0;
					count_q[c] <= '0;
					sums_q[c]  <= '0;
				end
			end else if (!done_q[ctx]) begin
				if (resting) begin
					sums_q[ctx]  <= sums_inc;
					count_q[ctx] <= count_inc;
					if (learn) begin
						done_q[ctx] <= 1'b1;
					end
				end else begin
					sums_q[ctx]  <= '0;
					count_q[ctx] <= '0;
				end
			end
		end
	end

	// Store learned centers, or drop both back to midpoint on reset op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				centers_q[c] <= MidAxes;
			end
		end else if (adv1) begin
			if (item_s1.op == sacl_pkg::OP_RESET) begin
				for (int c = 0; c < 2; c++) begin
					centers_q[c] <= MidAxes;
				end
			end else if (learn) begin
				centers_q[ctx] <= quot;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			result_q <= result_d;
		end
	end

endmodule
